// ----- design/assert_macros.svh -----
// assertion helpers used by split_tree_validator.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// plain clocked property, disabled while reset is active
`define STV_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("split tree check failed");

// overlapping implication, disabled while reset is active
`define STV_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("split tree implication failed");

// next-cycle implication, disabled while reset is active
`define STV_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("split tree sequence failed");

`else

`define STV_ASSERT(lbl, clk, rst_n, prop)
`define STV_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define STV_ASSERT_NXT(lbl, clk, rst_n, pre, post)

`endif

`endif

// ----- design/stv_pkg.sv -----
package stv_pkg;

    // largest legal rectangle dimension
    localparam logic [31:0] MAX_DIM = 32'h0004_0000;

    // deepest frame stack a legal tree reaches (18 halvings per axis)
    localparam int MAX_FRAMES = 36;

    // tag byte codes
    localparam logic [7:0] TAG_LEAF  = 8'd0;
    localparam logic [7:0] TAG_VERT  = 8'd1;
    localparam logic [7:0] TAG_HORIZ = 8'd2;
    localparam logic [7:0] TAG_QUAD  = 8'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_IMAGE_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [1:0] CFG_EXPECTED_LEAVES = 2'd2;

    // result kinds
    localparam logic KIND_LEAF   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // final status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_DIM   = 3'd1,
        ST_BAD_TAG   = 3'd2,
        ST_TOO_MANY  = 3'd3,
        ST_TRAILING  = 3'd4,
        ST_TRUNCATED = 3'd5,
        ST_TOO_FEW   = 3'd6
    } t_status;

    // one split still handing out children
    // split bit 0 halves the width, bit 1 halves the height
    // child is the number of the next child to hand out
    typedef struct packed {
        logic [17:0] x;
        logic [17:0] y;
        logic [18:0] w;
        logic [18:0] h;
        logic [1:0]  split;
        logic [1:0]  child;
    } t_frame;

    // one result beat
    typedef struct packed {
        logic        kind;
        logic [17:0] x;
        logic [17:0] y;
        logic [18:0] w;
        logic [18:0] h;
        logic [21:0] index;
        t_status     code;
        logic        eor;
    } t_result;

endpackage

// ----- design/split_tree_validator.sv -----
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+--------------------------------------
// input     | in        | i_in_valid / o_in_stall   | i_tag_byte, i_last_byte
// output    | out       | o_out_valid / i_out_stall | kind, x, y, w, h, index, status, eor
// config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one tag byte per cycle while the queue has room: a byte is registered, then resolved against
// the frame stack (top frame in flops, the rest in a memory with a prefetched next entry)
// a resolved byte's beats are written into the four-entry output queue, and the head beat
// is driven from the queue registers; a byte with a leaf and a status costs two beats
// synchronous active-low reset clears control state; no clearing pass is needed
// a byte waits while the queue holds over two beats, so output stall backs up to o_in_stall
`include "assert_macros.svh"

module split_tree_validator #(
    parameter int STACK_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_tag_byte,
    input  logic        i_last_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [17:0] o_leaf_x,
    output logic [17:0] o_leaf_y,
    output logic [18:0] o_leaf_w,
    output logic [18:0] o_leaf_h,
    output logic [21:0] o_leaf_index,
    output logic [2:0]  o_status_code,
    output logic        o_end_of_run,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import stv_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    // configuration
    logic [31:0] r_img_w;
    logic [31:0] r_img_h;
    logic [22:0] r_exp;

    // input register
    logic        r_in_vld;
    logic [7:0]  r_in_tag;
    logic        r_in_last;

    // tree state
    t_frame          r_top;
    t_frame          r_below;
    t_frame          mem [STACK_DEPTH];
    logic [DW-1:0]   r_depth;
    logic            r_at_start;
    logic [22:0]     r_leaves;
    t_status         r_sticky;

    // output queue
    t_result     r_q [4];
    logic [1:0]  r_head;
    logic [2:0]  r_cnt;

    // next-state and datapath signals
    logic            proc;
    logic            in_take;
    logic            out_pop;
    t_frame          n_top;
    logic [DW-1:0]   n_depth;
    logic [DW-1:0]   depth_m1;
    logic [DW-1:0]   n_depth_m2;
    logic [AW-1:0]   wr_idx;
    logic [AW-1:0]   rd_idx;
    logic            n_at_start;
    logic [22:0]     n_leaves;
    t_status         n_sticky;
    t_status         fin_code;
    t_frame          step_top;
    t_frame          new_frame;
    logic            mem_we;
    logic            took_child;
    logic            pop_top;
    logic            push_new;
    logic            have;
    logic            emit_leaf;
    logic            hs;
    logic            vs;
    logic            go_right;
    logic            go_down;
    logic            last_child;
    logic [18:0]     w1;
    logic [18:0]     w2;
    logic [18:0]     h1;
    logic [18:0]     h2;
    logic [17:0]     cx;
    logic [17:0]     cy;
    logic [18:0]     cw;
    logic [18:0]     ch;
    logic [17:0]     cur_x;
    logic [17:0]     cur_y;
    logic [31:0]     cur_w;
    logic [31:0]     cur_h;
    logic            bad_dim;
    t_result         leaf_res;
    t_result         stat_res;
    logic [1:0]      tail;

    // handshakes
    assign proc        = r_in_vld && (r_cnt <= 3'd2);
    assign o_in_stall  = r_in_vld && !proc;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_cnt != 3'd0);
    assign out_pop     = o_out_valid && !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= 32'd1;
            r_img_h <= 32'd1;
            r_exp   <= 23'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:     r_img_w <= i_cfg_data;
                CFG_IMAGE_HEIGHT:    r_img_h <= i_cfg_data;
                CFG_EXPECTED_LEAVES: r_exp   <= i_cfg_data[22:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (proc) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_tag  <= i_tag_byte;
            r_in_last <= i_last_byte;
        end
    end

    // next child of the top frame
    always_comb begin
        hs         = r_top.split[0];
        vs         = r_top.split[1];
        go_right   = hs && r_top.child[0];
        go_down    = vs && (hs ? r_top.child[1] : r_top.child[0]);
        last_child = (r_top.child == ((hs && vs) ? 2'd3 : 2'd1));
        w1         = {1'b0, r_top.w[18:1]};
        w2         = r_top.w - w1;
        h1         = {1'b0, r_top.h[18:1]};
        h2         = r_top.h - h1;
        cw         = hs ? (go_right ? w2 : w1) : r_top.w;
        ch         = vs ? (go_down ? h2 : h1) : r_top.h;
        cx         = r_top.x + (go_right ? w1[17:0] : 18'd0);
        cy         = r_top.y + (go_down ? h1[17:0] : 18'd0);
        step_top       = r_top;
        step_top.child = r_top.child + 2'd1;
    end

    // resolve one tag byte
    always_comb begin
        n_at_start = r_at_start;
        n_leaves   = r_leaves;
        n_sticky   = r_sticky;
        have       = 1'b0;
        took_child = 1'b0;
        push_new   = 1'b0;
        emit_leaf  = 1'b0;
        bad_dim    = 1'b0;
        cur_x      = 18'd0;
        cur_y      = 18'd0;
        cur_w      = r_img_w;
        cur_h      = r_img_h;

        if (proc) begin
            n_at_start = 1'b0;
            if (r_sticky == ST_OK) begin
                // pick the rectangle this byte describes
                if (r_at_start) begin
                    have = 1'b1;
                end else if (r_depth != '0) begin
                    have       = 1'b1;
                    took_child = 1'b1;
                    cur_x      = cx;
                    cur_y      = cy;
                    cur_w      = {13'd0, cw};
                    cur_h      = {13'd0, ch};
                end else begin
                    n_sticky = ST_TRAILING;
                end

                if (have) begin
                    bad_dim = (cur_w == 32'd0) || (cur_h == 32'd0) || (cur_w > MAX_DIM)
                              || (cur_h > MAX_DIM);
                    if (bad_dim) begin
                        n_sticky = ST_BAD_DIM;
                    end else begin
                        case (r_in_tag)
                            TAG_LEAF: begin
                                if (r_leaves >= r_exp) begin
                                    n_sticky = ST_TOO_MANY;
                                end else begin
                                    emit_leaf = 1'b1;
                                    n_leaves  = r_leaves + 23'd1;
                                end
                            end
                            TAG_VERT: begin
                                if (cur_w < 32'd2) n_sticky = ST_BAD_DIM;
                                else push_new = 1'b1;
                            end
                            TAG_HORIZ: begin
                                if (cur_h < 32'd2) n_sticky = ST_BAD_DIM;
                                else push_new = 1'b1;
                            end
                            TAG_QUAD: begin
                                if (cur_w < 32'd2 || cur_h < 32'd2) n_sticky = ST_BAD_DIM;
                                else push_new = 1'b1;
                            end
                            default: begin
                                n_sticky = ST_BAD_TAG;
                            end
                        endcase
                    end
                end
            end
        end
    end

    assign pop_top = took_child && last_child;

    always_comb begin
        new_frame.x     = cur_x;
        new_frame.y     = cur_y;
        new_frame.w     = cur_w[18:0];
        new_frame.h     = cur_h[18:0];
        new_frame.split = r_in_tag[1:0];
        new_frame.child = 2'd0;
    end

    // frame stack update
    always_comb begin
        n_top   = r_top;
        n_depth = r_depth;
        mem_we  = 1'b0;
        if (push_new) begin
            n_top = new_frame;
            if (!pop_top) begin
                n_depth = r_depth + DW'(1);
                mem_we  = (r_depth != '0);
            end
        end else if (pop_top) begin
            n_top   = r_below;
            n_depth = r_depth - DW'(1);
        end else if (took_child) begin
            n_top = step_top;
        end
    end

    // final status from the state this byte leaves
    always_comb begin
        fin_code = n_sticky;
        if (n_sticky == ST_OK) begin
            if (n_depth != '0) fin_code = ST_TRUNCATED;
            else if (n_leaves != r_exp) fin_code = ST_TOO_FEW;
        end
    end

    assign depth_m1   = r_depth - DW'(1);
    assign wr_idx     = depth_m1[AW-1:0];
    assign n_depth_m2 = (proc && r_in_last) ? DW'(0) - DW'(2) : n_depth - DW'(2);
    assign rd_idx     = n_depth_m2[AW-1:0];

    // tree state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth    <= '0;
            r_at_start <= 1'b1;
            r_leaves   <= 23'd0;
            r_sticky   <= ST_OK;
        end else if (proc && r_in_last) begin
            r_depth    <= '0;
            r_at_start <= 1'b1;
            r_leaves   <= 23'd0;
            r_sticky   <= ST_OK;
        end else begin
            r_depth    <= n_depth;
            r_at_start <= n_at_start;
            r_leaves   <= n_leaves;
            r_sticky   <= n_sticky;
        end
    end

    // top frame and stack memory with prefetched entry below the top
    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (mem_we) begin
            mem[wr_idx] <= step_top;
            r_below     <= step_top;
        end else begin
            r_below <= mem[rd_idx];
        end
    end

    // result beats
    always_comb begin
        leaf_res.kind  = KIND_LEAF;
        leaf_res.x     = cur_x;
        leaf_res.y     = cur_y;
        leaf_res.w     = cur_w[18:0];
        leaf_res.h     = cur_h[18:0];
        leaf_res.index = r_leaves[21:0];
        leaf_res.code  = ST_OK;
        leaf_res.eor   = !r_in_last;
        stat_res.kind  = KIND_STATUS;
        stat_res.x     = 18'd0;
        stat_res.y     = 18'd0;
        stat_res.w     = 19'd0;
        stat_res.h     = 19'd0;
        stat_res.index = 22'd0;
        stat_res.code  = fin_code;
        stat_res.eor   = 1'b1;
    end

    // output queue
    assign tail = r_head + r_cnt[1:0];

    always_ff @(posedge i_clk) begin
        if (proc) begin
            if (emit_leaf) begin
                r_q[tail] <= leaf_res;
                if (r_in_last) r_q[tail + 2'd1] <= stat_res;
            end else if (r_in_last) begin
                r_q[tail] <= stat_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 2'd0;
            r_cnt  <= 3'd0;
        end else begin
            if (out_pop) r_head <= r_head + 2'd1;
            r_cnt <= r_cnt + 3'(proc && emit_leaf) + 3'(proc && r_in_last)
                     - 3'(out_pop);
        end
    end

    assign o_result_kind = r_q[r_head].kind;
    assign o_leaf_x      = r_q[r_head].x;
    assign o_leaf_y      = r_q[r_head].y;
    assign o_leaf_w      = r_q[r_head].w;
    assign o_leaf_h      = r_q[r_head].h;
    assign o_leaf_index  = r_q[r_head].index;
    assign o_status_code = r_q[r_head].code;
    assign o_end_of_run  = r_q[r_head].eor;

    // checks
    `STV_ASSERT(a_depth_bound, i_clk, i_rst_n, r_depth <= DW'(MAX_FRAMES))
    `STV_ASSERT_NXT(a_last_rearms, i_clk, i_rst_n, proc && r_in_last,
                    r_depth == '0 && r_at_start && r_sticky == ST_OK)
    `STV_ASSERT_NXT(a_quiet_after_err, i_clk, i_rst_n,
                    proc && !r_in_last && r_sticky != ST_OK, r_cnt <= $past(r_cnt))
    `STV_ASSERT_IMP(a_queue_room, i_clk, i_rst_n, proc, r_cnt <= 3'd2)

endmodule
